// ===== rtl/cdn_pkg.sv =====
package cdn_pkg;

   localparam int NUM_W = 22;

   localparam logic [1:0] ORDER_EARLIER = 2'd0;
   localparam logic [1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [1:0] ORDER_LATER   = 2'd2;

   // reciprocal of 100 scaled by 2^22, exact floor for 12 bit values
   localparam logic [15:0] RECIP_100 = 16'd41944;
   // reciprocal of the mean year length scaled by 2^24, rounded down
   localparam logic [15:0] RECIP_YEAR = 16'd45934;

   typedef struct packed {
      logic [2:0] load;
   } to_num_ctl_type;

   typedef struct packed {
      logic [6:0] load;
   } from_num_ctl_type;

   typedef struct packed {
      logic [16:0] day_number;
      logic [16:0] sum_day_number;
      logic [17:0] difference;
      logic [1:0]  order;
   } tail_type;

   function automatic int days_before_year(input int y);
      int p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] r;
      unique case (m)
         4'd2:    r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/civil_date_day_number_unit_core.sv =====
// Gregorian date unit: each request carries a first date, a second date and a
// signed day offset. Out-of-range fields are replaced (year by 2000 or by
// BASE_YEAR if 2000 is outside the range, month by 1, day by 1 with the day
// checked against the corrected month). The result gives the day number of the
// first date (1 is BASE_YEAR-01-01), the date and day number reached by adding
// the offset clamped to the first and last days of the range, the difference
// of the two day numbers and their order. Fields wider than their port are
// truncated. The block is an 11 stage pipeline: one request is taken every
// cycle while the output is not stalled, and each stage holds when its successor
// is full and stalled, so stalls lose and repeat nothing.
module civil_date_day_number_unit_core #(
   parameter int BASE_YEAR = 1900,
   parameter int LAST_YEAR = 2099
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // year[11:0] month[15:12] day[20:16] offset[38:21]
   // other_year[50:39] other_month[54:51] other_day[59:55]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // day_number[16:0] sum_year[28:17] sum_month[32:29] sum_day[37:33]
   // sum_day_number[54:38] difference[72:55] order[74:73]
   output logic [79:0] rsp_tdata
);

   localparam int TOP_YEAR  = (LAST_YEAR < BASE_YEAR) ? BASE_YEAR : LAST_YEAR;
   localparam int REPL_YEAR = (2000 >= BASE_YEAR && 2000 <= TOP_YEAR) ? 2000 : BASE_YEAR;
   localparam int BASE_DAYS = cdn_pkg::days_before_year(BASE_YEAR);
   localparam int LAST_NUM  = cdn_pkg::days_before_year(TOP_YEAR + 1) - BASE_DAYS;
   localparam int NW        = cdn_pkg::NUM_W;
   localparam int NST       = 11;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;
   logic [NST-1:0] en;

   cdn_pkg::to_num_ctl_type   to_ctl;
   cdn_pkg::from_num_ctl_type from_ctl;

   logic [NW-1:0] n1, n2;
   logic signed [17:0] off0_ff, off1_ff, off2_ff;

   logic signed [NW-1:0] sum_raw;
   logic signed [NW-1:0] sum_cl;
   logic signed [NW-1:0] diff;
   logic [1:0]    ord;
   logic [NW-1:0] sum_ff;
   cdn_pkg::tail_type tail_in, tail_ff, tail_out;

   logic [11:0] s_year;
   logic [3:0]  s_month;
   logic [4:0]  s_day;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_tready;
      for (int i = NST - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i + 1];
      end
      for (int i = 0; i < NST; i++) begin
         if (en[i]) begin
            v_in[i] = (i == 0) ? req_tvalid : v_ff[(i == 0) ? 0 : i - 1];
         end else begin
            v_in[i] = v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign to_ctl.load   = en[2:0];
   assign from_ctl.load = en[10:4];

   cdn_to_number #(
      .BASE_YEAR (BASE_YEAR),
      .TOP_YEAR  (TOP_YEAR),
      .REPL_YEAR (REPL_YEAR),
      .BASE_DAYS (BASE_DAYS)
   ) u_first (
      .clock  (clock),
      .ctl    (to_ctl),
      .year   (req_tdata[11:0]),
      .month  (req_tdata[15:12]),
      .day    (req_tdata[20:16]),
      .number (n1)
   );

   cdn_to_number #(
      .BASE_YEAR (BASE_YEAR),
      .TOP_YEAR  (TOP_YEAR),
      .REPL_YEAR (REPL_YEAR),
      .BASE_DAYS (BASE_DAYS)
   ) u_second (
      .clock  (clock),
      .ctl    (to_ctl),
      .year   (req_tdata[50:39]),
      .month  (req_tdata[54:51]),
      .day    (req_tdata[59:55]),
      .number (n2)
   );

   always_ff @(posedge clock) begin
      if (en[0]) begin
         off0_ff <= $signed(req_tdata[38:21]);
      end
      if (en[1]) begin
         off1_ff <= off0_ff;
      end
      if (en[2]) begin
         off2_ff <= off1_ff;
      end
   end

   // offset sum with clamp, difference and order
   always_comb begin
      sum_raw = $signed(n1) + NW'(off2_ff);
      priority if (sum_raw < $signed(NW'(1))) begin
         sum_cl = NW'(1);
      end else if (sum_raw > $signed(NW'(LAST_NUM))) begin
         sum_cl = NW'(LAST_NUM);
      end else begin
         sum_cl = sum_raw;
      end
      diff = $signed(n1) - $signed(n2);
      priority if (n1 < n2) begin
         ord = cdn_pkg::ORDER_EARLIER;
      end else if (n1 == n2) begin
         ord = cdn_pkg::ORDER_EQUAL;
      end else begin
         ord = cdn_pkg::ORDER_LATER;
      end
      tail_in.day_number     = n1[16:0];
      tail_in.sum_day_number = sum_cl[16:0];
      tail_in.difference     = diff[17:0];
      tail_in.order          = ord;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         sum_ff  <= sum_cl;
         tail_ff <= tail_in;
      end
   end

   cdn_from_number #(
      .BASE_DAYS (BASE_DAYS)
   ) u_from (
      .clock    (clock),
      .ctl      (from_ctl),
      .number   (sum_ff),
      .tail     (tail_ff),
      .year     (s_year),
      .month    (s_month),
      .day      (s_day),
      .tail_out (tail_out)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NST-1];
   assign rsp_tdata  = {5'd0, tail_out.order, tail_out.difference,
                        tail_out.sum_day_number, s_day, s_month, s_year,
                        tail_out.day_number};

`ifndef ASSERT_OFF
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_tready |-> !req_tready)
      else $error("request taken with a full stalled pipeline");

   a_order_diff : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((tail_out.order == cdn_pkg::ORDER_EQUAL) ==
                      (tail_out.difference == 18'd0)))
      else $error("order disagrees with difference");

   a_sum_date : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (s_month >= 4'd1 && s_month <= 4'd12 && s_day >= 5'd1 &&
                      s_year >= 12'(BASE_YEAR) && s_year <= 12'(TOP_YEAR)))
      else $error("sum date out of range");

   a_advance : assert property (@(posedge clock) disable iff (reset)
      v_ff[3] && en[4] |=> v_ff[4])
      else $error("item lost between stages");
`endif

endmodule

// ===== rtl/cdn_to_number.sv =====
module cdn_to_number #(
   parameter int BASE_YEAR = 1900,
   parameter int TOP_YEAR  = 2099,
   parameter int REPL_YEAR = 2000,
   parameter int BASE_DAYS = 693595
) (
   input  logic                       clock,
   input  cdn_pkg::to_num_ctl_type    ctl,
   input  logic [11:0]                year,
   input  logic [3:0]                 month,
   input  logic [4:0]                 day,
   output logic [cdn_pkg::NUM_W-1:0]  number
);

   logic [11:0] yc;
   logic [11:0] p;
   logic [27:0] prod;
   logic [3:0]  mc;

   logic [11:0] p_ff;
   logic [5:0]  pq_ff;
   logic [3:0]  mo_ff;
   logic [4:0]  dy_ff;

   logic [11:0] r100;
   logic        leap;
   logic [4:0]  mlen;
   logic [4:0]  dc;
   logic [cdn_pkg::NUM_W-1:0] ypart_in;

   logic [cdn_pkg::NUM_W-1:0] ypart_ff;
   logic [3:0]  mo2_ff;
   logic [4:0]  dy2_ff;
   logic        leap_ff;

   logic [cdn_pkg::NUM_W-1:0] number_in;
   logic [cdn_pkg::NUM_W-1:0] number_ff;

   // year and month fix, year divided by 100
   always_comb begin
      if (year < 12'(BASE_YEAR) || year > 12'(TOP_YEAR)) begin
         yc = 12'(REPL_YEAR);
      end else begin
         yc = year;
      end
      p    = yc - 12'd1;
      prod = {16'd0, p} * {12'd0, cdn_pkg::RECIP_100};
      if (month < 4'd1 || month > 4'd12) begin
         mc = 4'd1;
      end else begin
         mc = month;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         p_ff  <= p;
         pq_ff <= prod[27:22];
         mo_ff <= mc;
         dy_ff <= day;
      end
   end

   // leap year, day fix, days before the year
   always_comb begin
      r100 = p_ff - 12'({6'd0, pq_ff} * 12'd100);
      leap = (p_ff[1:0] == 2'd3 && r100 != 12'd99) ||
             (r100 == 12'd99 && pq_ff[1:0] == 2'd3);
      mlen = cdn_pkg::month_len(mo_ff, leap);
      if (dy_ff == 5'd0 || dy_ff > mlen) begin
         dc = 5'd1;
      end else begin
         dc = dy_ff;
      end
      ypart_in = cdn_pkg::NUM_W'(p_ff) * cdn_pkg::NUM_W'(365)
               + cdn_pkg::NUM_W'(p_ff[11:2])
               - cdn_pkg::NUM_W'(pq_ff)
               + cdn_pkg::NUM_W'(pq_ff[5:2])
               - cdn_pkg::NUM_W'(BASE_DAYS);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         ypart_ff <= ypart_in;
         mo2_ff   <= mo_ff;
         dy2_ff   <= dc;
         leap_ff  <= leap;
      end
   end

   assign number_in = ypart_ff
                    + cdn_pkg::NUM_W'(cdn_pkg::days_before_month(mo2_ff))
                    + cdn_pkg::NUM_W'(leap_ff && mo2_ff > 4'd2)
                    + cdn_pkg::NUM_W'(dy2_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         number_ff <= number_in;
      end
   end

   assign number = number_ff;

endmodule

// ===== rtl/cdn_from_number.sv =====
module cdn_from_number #(
   parameter int BASE_DAYS = 693595
) (
   input  logic                       clock,
   input  cdn_pkg::from_num_ctl_type  ctl,
   input  logic [cdn_pkg::NUM_W-1:0]  number,
   input  cdn_pkg::tail_type          tail,
   output logic [11:0]                year,
   output logic [3:0]                 month,
   output logic [4:0]                 day,
   output cdn_pkg::tail_type          tail_out
);

   localparam int NW = cdn_pkg::NUM_W;

   cdn_pkg::tail_type tail_ff [7];

   logic [NW-1:0] da_ff, db_ff, dc_ff, dd_ff;
   logic [NW+15:0] est;
   logic [13:0]   e;
   logic [11:0]   e2_ff, e2c_ff, e2d_ff;
   logic [11:0]   x [3];
   logic [27:0]   qprod [3];
   logic [5:0]    q_ff [3];
   logic [11:0]   r [3];
   logic [2:0]    leap_in;
   logic [2:0]    leap_ff;
   logic [NW-1:0] s0_in, s0_ff;

   logic signed [NW-1:0] rem0, rem1, rem2;
   logic [8:0]    rem_in, rem_ff;
   logic [11:0]   yr_in, yr_ff, yr2_ff, yr3_ff;
   logic          lsel_in, lsel_ff, lsel2_ff;

   logic [3:0]    mo_in, mo_ff, mo3_ff;
   logic [8:0]    rem2_ff;
   logic [8:0]    th;
   logic [4:0]    dy_in, dy_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 7; i++) begin
         if (ctl.load[i]) begin
            tail_ff[i] <= (i == 0) ? tail : tail_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // absolute day count from the first day of the era
   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         da_ff <= number - NW'(1) + NW'(BASE_DAYS);
      end
   end

   // year estimate, may be one off either way
   always_comb begin
      est = {16'd0, da_ff} * {{NW{1'b0}}, cdn_pkg::RECIP_YEAR};
      e   = est[NW+15:24];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         db_ff <= da_ff;
         e2_ff <= 12'(e - 14'd1);
      end
   end

   // three candidate years divided by 100
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         x[k]     = e2_ff + 12'(k);
         qprod[k] = {16'd0, x[k]} * {12'd0, cdn_pkg::RECIP_100};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         dc_ff  <= db_ff;
         e2c_ff <= e2_ff;
         for (int k = 0; k < 3; k++) begin
            q_ff[k] <= qprod[k][27:22];
         end
      end
   end

   // leap flags of the candidates and start of the first one
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r[k] = (e2c_ff + 12'(k)) - 12'({6'd0, q_ff[k]} * 12'd100);
         leap_in[k] = ((e2c_ff[1:0] + 2'(k)) == 2'd3 && r[k] != 12'd99) ||
                      (r[k] == 12'd99 && q_ff[k][1:0] == 2'd3);
      end
      s0_in = NW'(e2c_ff) * NW'(365) + NW'(e2c_ff[11:2])
            - NW'(q_ff[0]) + NW'(q_ff[0][5:2]);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         dd_ff   <= dc_ff;
         e2d_ff  <= e2c_ff;
         leap_ff <= leap_in;
         s0_ff   <= s0_in;
      end
   end

   // pick the year and the day within it
   always_comb begin
      rem0 = $signed(dd_ff - s0_ff);
      rem1 = rem0 - $signed(NW'(365) + NW'(leap_ff[0]));
      rem2 = rem1 - $signed(NW'(365) + NW'(leap_ff[1]));
      priority if (rem2 >= 0) begin
         rem_in  = rem2[8:0];
         yr_in   = e2d_ff + 12'd3;
         lsel_in = leap_ff[2];
      end else if (rem1 >= 0) begin
         rem_in  = rem1[8:0];
         yr_in   = e2d_ff + 12'd2;
         lsel_in = leap_ff[1];
      end else begin
         rem_in  = rem0[8:0];
         yr_in   = e2d_ff + 12'd1;
         lsel_in = leap_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         rem_ff  <= rem_in;
         yr_ff   <= yr_in;
         lsel_ff <= lsel_in;
      end
   end

   // month by counting passed month starts
   always_comb begin
      mo_in = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         th = cdn_pkg::days_before_month(4'(m)) + 9'(lsel_ff && m > 2);
         mo_in = mo_in + 4'(rem_ff >= th);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         mo_ff    <= mo_in;
         rem2_ff  <= rem_ff;
         yr2_ff   <= yr_ff;
         lsel2_ff <= lsel_ff;
      end
   end

   assign dy_in = 5'(rem2_ff - cdn_pkg::days_before_month(mo_ff)
                  - 9'(lsel2_ff && mo_ff > 4'd2) + 9'd1);

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         dy_ff  <= dy_in;
         mo3_ff <= mo_ff;
         yr3_ff <= yr2_ff;
      end
   end

   assign year     = yr3_ff;
   assign month    = mo3_ff;
   assign day      = dy_ff;
   assign tail_out = tail_ff[6];

endmodule
